[sv/pcsc_pkg.sv]
// Package for the per-client sequence checker: widths, table entry and status codes.
// No dependencies; every other file of the block imports it.
package pcsc_pkg;

    localparam int MAX_CLIENTS = 256;
    localparam int CID_BITS    = $clog2(MAX_CLIENTS);
    localparam int SEQ_BITS    = 32;

    localparam int KIND_W = 1;
    localparam int CLID_W = 8;
    localparam int CONN_W = 16;
    localparam int SEQN_W = 32;
    localparam int OSEQ_W = 32;

    localparam logic [KIND_W-1:0] KIND_REQUEST  = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RESPONSE = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_WRONG_CONN = 3'd1,
        ST_WRONG_SEQ  = 3'd2,
        ST_STAMPED    = 3'd3,
        ST_NO_CONN    = 3'd4
    } t_status;

    typedef struct packed {
        logic [CONN_W-1:0]   conn;
        logic [SEQ_BITS-1:0] exp_seq;
        logic [SEQ_BITS-1:0] out_seq;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

endpackage

[sv/pcsc_if.sv]
// Valid/ready channel interfaces for request beats and result beats.
// Depends on pcsc_pkg for field widths and the status type.
interface pcsc_req_if import pcsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CLID_W-1:0] client_no;
    logic [CONN_W-1:0] connection_id;
    logic [SEQN_W-1:0] seq_num;

    modport source (output valid, kind, client_no, connection_id, seq_num, input ready);
    modport sink   (input valid, kind, client_no, connection_id, seq_num, output ready);
endinterface

interface pcsc_rsp_if import pcsc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [OSEQ_W-1:0] out_seq;
    logic [CONN_W-1:0] dest_connection;

    modport source (output valid, status, out_seq, dest_connection, input ready);
    modport sink   (input valid, status, out_seq, dest_connection, output ready);
endinterface

[sv/per_client_sequence_checker_core.sv]
// Top level of the per-client sequence checker: controller plus datapath.
// Depends on pcsc_pkg, pcsc_if, pcsc_ctrl and pcsc_dp.
//
// Usage:
//   i_req carries one beat per message: kind (request or response to stamp),
//   client_no, connection_id and seq_num. o_rsp returns exactly one beat per
//   request beat: status, out_seq and dest_connection, in arrival order.
//   A request binds its client to its connection on first sight; responses
//   take the client's outbound number and bound connection.
// Timing:
//   The accept edge reads the client table (one memory, registered read);
//   the commit edge then writes it back and loads the result register. The
//   commit waits while the result register is full and not being taken. The
//   result is valid from the commit edge; no new beat enters until the last
//   has committed, set by that read-modify-write of the table.
// Stalls:
//   The result register holds while o_rsp.ready is low; the next request is
//   still taken and waits after its table read until the register frees.
// Reset:
//   Synchronous reset clears all bound flags (both counters read as one for
//   unbound clients) and the handshake state; no clearing pass is needed.
module per_client_sequence_checker_core import pcsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcsc_req_if.sink   i_req,
    pcsc_rsp_if.source o_rsp
);

    t_cmd cmd;
    logic out_valid;

    pcsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    pcsc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_kind            (i_req.kind),
        .i_client_no       (i_req.client_no),
        .i_connection_id   (i_req.connection_id),
        .i_seq_num         (i_req.seq_num),
        .o_status          (o_rsp.status),
        .o_out_seq         (o_rsp.out_seq),
        .o_dest_connection (o_rsp.dest_connection)
    );

    assign o_rsp.valid = out_valid;

endmodule

[sv/pcsc_ctrl.sv]
// Controller of the sequence checker: sequences capture, table read and commit.
// Depends on pcsc_pkg for the command struct.
module pcsc_ctrl import pcsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   capture, commit;

    assign capture = (r_state == S_IDLE) && i_in_valid;
    // commit only when the result register is free or being emptied
    assign commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (capture) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = capture;
    assign o_cmd.commit  = commit;

endmodule

[sv/pcsc_dp.sv]
// Datapath of the sequence checker: client table memory, bound flags,
// check and stamp logic, result register. Depends on pcsc_pkg.
module pcsc_dp import pcsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [CLID_W-1:0] i_client_no,
    input  logic [CONN_W-1:0] i_connection_id,
    input  logic [SEQN_W-1:0] i_seq_num,
    output t_status           o_status,
    output logic [OSEQ_W-1:0] o_out_seq,
    output logic [CONN_W-1:0] o_dest_connection
);

    t_entry                r_mem [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] r_bound;

    logic [KIND_W-1:0]   r_kind;
    logic [CID_BITS-1:0] r_cid;
    logic [CONN_W-1:0]   r_conn;
    logic [SEQN_W-1:0]   r_seq;
    t_entry              r_rd;

    t_status             r_status;
    logic [OSEQ_W-1:0]   r_out_seq;
    logic [CONN_W-1:0]   r_dest;

    logic                bound;
    t_entry              cur;
    t_entry              n_entry;
    logic                wr_en;
    t_status             n_status;
    logic [OSEQ_W-1:0]   n_out_seq;
    logic [CONN_W-1:0]   n_dest;

    assign bound = r_bound[r_cid];

    // an unbound entry reads as: connection of this beat, both counters at one
    always_comb begin
        if (bound) begin
            cur = r_rd;
        end else begin
            cur.conn    = r_conn;
            cur.exp_seq = SEQ_BITS'(1);
            cur.out_seq = SEQ_BITS'(1);
        end
    end

    always_comb begin
        n_entry   = cur;
        wr_en     = 1'b0;
        n_out_seq = '0;
        n_dest    = '0;
        n_status  = ST_NO_CONN;
        if (r_kind == KIND_REQUEST) begin
            wr_en  = 1'b1;
            n_dest = cur.conn;
            if (cur.conn != r_conn) begin
                n_status = ST_WRONG_CONN;
            end else if (r_seq != cur.exp_seq) begin
                n_status = ST_WRONG_SEQ;
            end else begin
                n_status        = ST_ACCEPTED;
                n_entry.exp_seq = cur.exp_seq + SEQ_BITS'(1);
            end
        end else if (bound) begin
            wr_en           = 1'b1;
            n_status        = ST_STAMPED;
            n_dest          = cur.conn;
            n_out_seq       = OSEQ_W'(cur.out_seq);
            n_entry.out_seq = cur.out_seq + SEQ_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_cid  <= i_client_no[CID_BITS-1:0];
            r_conn <= i_connection_id;
            r_seq  <= i_seq_num;
            r_rd   <= r_mem[i_client_no[CID_BITS-1:0]];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem[r_cid] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= '0;
        end else if (i_cmd.commit && wr_en) begin
            r_bound[r_cid] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_out_seq <= n_out_seq;
            r_dest    <= n_dest;
        end
    end

    assign o_status          = r_status;
    assign o_out_seq         = r_out_seq;
    assign o_dest_connection = r_dest;

endmodule

[sv/pcsc_checker.sv]
// Port-level checks for the per-client sequence checker, bound to the top level.
// Depends on pcsc_pkg for the status codes.
module pcsc_checker import pcsc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input t_status           i_rsp_status,
    input logic [OSEQ_W-1:0] i_rsp_out_seq,
    input logic [CONN_W-1:0] i_rsp_dest
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_out_seq) && $stable(i_rsp_dest))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid straight after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while table update pending");

    a_no_conn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_NO_CONN |-> i_rsp_out_seq == '0 && i_rsp_dest == '0)
        else $error("unbound response carries stamp or route");

    a_request_no_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == ST_ACCEPTED || i_rsp_status == ST_WRONG_CONN
            || i_rsp_status == ST_WRONG_SEQ) |-> i_rsp_out_seq == '0)
        else $error("request result carries a stamp");

endmodule

bind per_client_sequence_checker_core pcsc_checker u_pcsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_out_seq (o_rsp.out_seq),
    .i_rsp_dest    (o_rsp.dest_connection)
);
